// ===== rtl/core/fwna_pkg.sv =====
// Package for the fixed-width number to ASCII block.
// Format codes, character constants and controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps

package fwna_pkg;

  localparam logic [1:0] FMT_UDEC = 2'd0;
  localparam logic [1:0] FMT_SDEC = 2'd1;
  localparam logic [1:0] FMT_HEX  = 2'd2;
  localparam logic [1:0] FMT_BIN  = 2'd3;

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_UA    = 7'h41;
  localparam logic [6:0] CHAR_PLUS  = 7'h2B;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;

  localparam logic [5:0] MAX_DIGITS  = 6'd32;
  localparam int         DEC_DIGITS  = 10;
  localparam logic [5:0] DEC_LIMIT   = 6'd10;
  localparam logic [5:0] HEX_LIMIT   = 6'd8;
  localparam logic [4:0] CONV_LAST   = 5'd31;

  typedef struct packed {
    logic load;       // capture the input item
    logic conv_step;  // one double-dabble iteration
    logic emit_step;  // load next character into the output register
  } fwna_cmd_t;

  typedef struct packed {
    logic in_decimal; // input item is a decimal format
    logic conv_last;  // final conversion iteration
    logic remaining;  // characters still to be emitted
    logic out_free;   // output register can take a character
  } fwna_status_t;

endpackage

// ===== rtl/core/fwna_ctrl.sv =====
// Controller for the fixed-width number to ASCII block.
// Sequences capture, binary-to-BCD conversion and character emission.
// Depends on fwna_pkg.
`timescale 1ns / 1ps

module fwna_ctrl
  import fwna_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  fwna_status_t status,
  output fwna_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.in_decimal ? ST_CONV : ST_EMIT;
        end
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        if (status.conv_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!status.remaining) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.emit_step = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/fwna_datapath.sv =====
// Datapath for the fixed-width number to ASCII block.
// Item registers, shift-add-3 BCD converter, digit select and output register.
// Depends on fwna_pkg.
`timescale 1ns / 1ps

module fwna_datapath
  import fwna_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic [1:0]   cmd,
  input  logic [31:0]  number,
  input  logic [5:0]   digit_count,
  input  logic [2:0]   line,
  input  logic [4:0]   column,
  input  fwna_cmd_t    ctl,
  output fwna_status_t status,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [2:0]   out_line,
  output logic [5:0]   out_column,
  output logic [6:0]   char_code,
  output logic         last
);

  logic [1:0]  mode;
  logic [31:0] mag;
  logic [3:0]  bcd [DEC_DIGITS];
  logic [5:0]  len;
  logic [2:0]  line_r;
  logic [4:0]  col;
  logic [5:0]  idx;
  logic [4:0]  cnt;
  logic        sign_pending;
  logic        sign_neg;

  logic [3:0]  bcd_adj [DEC_DIGITS];
  logic [5:0]  pos;
  logic [3:0]  digit;
  logic [6:0]  ch;
  logic [5:0]  ch_col;
  logic        ch_last;
  logic        is_signed;

  assign is_signed = (mode == FMT_SDEC);

  always_comb begin
    for (int k = 0; k < DEC_DIGITS; k++) begin
      bcd_adj[k] = (bcd[k] >= 4'd5) ? bcd[k] + 4'd3 : bcd[k];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mode   <= cmd;
      len    <= (digit_count > MAX_DIGITS) ? MAX_DIGITS : digit_count;
      line_r <= line;
      col    <= column;
      if (cmd == FMT_SDEC && number[31]) begin
        mag <= 32'd0 - number;
      end else begin
        mag <= number;
      end
      sign_neg <= number[31];
      for (int k = 0; k < DEC_DIGITS; k++) begin
        bcd[k] <= 4'd0;
      end
    end else if (ctl.conv_step) begin
      // shift the adjusted BCD left by one, bringing in the next magnitude bit
      bcd[0] <= {bcd_adj[0][2:0], mag[31]};
      for (int k = 1; k < DEC_DIGITS; k++) begin
        bcd[k] <= {bcd_adj[k][2:0], bcd_adj[k-1][3]};
      end
      mag <= {mag[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      idx          <= '0;
      sign_pending <= 1'b0;
    end else if (ctl.load) begin
      cnt          <= '0;
      idx          <= '0;
      sign_pending <= (cmd == FMT_SDEC);
    end else begin
      if (ctl.conv_step) begin
        cnt <= cnt + 5'd1;
      end
      if (ctl.emit_step) begin
        if (sign_pending) begin
          sign_pending <= 1'b0;
        end else begin
          idx <= idx + 6'd1;
        end
      end
    end
  end

  // digit position counted from the least significant end
  assign pos = len - idx - 6'd1;

  always_comb begin
    case (mode)
      FMT_HEX: digit = (pos < HEX_LIMIT) ? mag[{pos[2:0], 2'b00} +: 4] : 4'd0;
      FMT_BIN: digit = {3'd0, mag[pos[4:0]]};
      default: digit = (pos < DEC_LIMIT) ? bcd[pos[3:0]] : 4'd0;
    endcase
  end

  always_comb begin
    if (sign_pending) begin
      ch      = sign_neg ? CHAR_MINUS : CHAR_PLUS;
      ch_col  = {1'b0, col};
      ch_last = (len == 6'd0);
    end else begin
      ch      = (digit < 4'd10) ? CHAR_ZERO + {3'd0, digit}
                                : CHAR_UA + {3'd0, digit} - 7'd10;
      ch_col  = {1'b0, col} + idx + {5'd0, is_signed};
      ch_last = (idx + 6'd1 == len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit_step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_step) begin
      out_line   <= line_r;
      out_column <= ch_col;
      char_code  <= ch;
      last       <= ch_last;
    end
  end

  assign status.in_decimal = (cmd == FMT_UDEC) || (cmd == FMT_SDEC);
  assign status.conv_last  = (cnt == CONV_LAST);
  assign status.remaining  = sign_pending || (idx != len);
  assign status.out_free   = !out_valid || out_ready;

endmodule

// ===== rtl/core/fixed_width_number_to_ascii.sv =====
// Top level of the fixed-width number to ASCII block.
// Joins the controller and the datapath. Depends on fwna_pkg, fwna_ctrl,
// fwna_datapath.
//
// Input channel (in_valid/in_ready): one item holds a format code, a 32-bit
// number, a digit count, a text line and a start column.
// Output channel (out_valid/out_ready): one item per character, most
// significant digit first, each with its line and column; last marks the
// final character. Signed decimal leads with '+' or '-'.
// Timing: an item is taken only when the block is idle. Decimal formats pass
// through the shift-add-3 BCD converter one magnitude bit per cycle; hex and
// binary skip it. Characters then leave at one per cycle while the receiver
// keeps out_ready high. The next item is taken only after every character of
// the last one (sign included) has entered the output register. A digit
// count of zero gives no characters, except the sign in signed decimal.
// A stalled receiver holds the current character and pauses emission; the
// next item is accepted while the final character still waits.
// Reset (rst, synchronous) empties the output register and returns to idle.
`timescale 1ns / 1ps

module fixed_width_number_to_ascii
  import fwna_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [31:0] number,
  input  logic [5:0]  digit_count,
  input  logic [2:0]  line,
  input  logic [4:0]  column,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_line,
  output logic [5:0]  out_column,
  output logic [6:0]  char_code,
  output logic        last
);

  fwna_cmd_t    ctl;
  fwna_status_t status;

  fwna_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (ctl)
  );

  fwna_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .number      (number),
    .digit_count (digit_count),
    .line        (line),
    .column      (column),
    .ctl         (ctl),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_line    (out_line),
    .out_column  (out_column),
    .char_code   (char_code),
    .last        (last)
  );

endmodule

// ===== rtl/core/fwna_checker.sv =====
// Port-level checks for the fixed-width number to ASCII block.
// Bound to fixed_width_number_to_ascii; depends on fwna_pkg.
`timescale 1ns / 1ps

module fwna_checker
  import fwna_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_line,
  input logic [5:0]  out_column,
  input logic [6:0]  char_code,
  input logic        last
);

  // one item at a time: no second item right after a capture
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // a character still waiting in the output register while idle is the final one of its run
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_ready |-> last)
    else $error("idle with a run unfinished");

  a_char_set: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_code >= CHAR_ZERO && char_code <= CHAR_ZERO + 7'd9) ||
                  (char_code >= CHAR_UA && char_code <= CHAR_UA + 7'd5) ||
                  char_code == CHAR_PLUS || char_code == CHAR_MINUS)
    else $error("character outside the digit set");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char_code) &&
                                $stable(out_column) && $stable(out_line) &&
                                $stable(last))
    else $error("stalled item changed");

endmodule

bind fixed_width_number_to_ascii fwna_checker u_fwna_checker (.*);
